// File: design/vga_scan_out_with_frame_store_top_assert.svh
// Assertion macros shared by the RTL of the VGA scan-out block.
// Each macro names the clock and the active-low reset of the module that uses it.
`ifndef VGA_SCAN_OUT_WITH_FRAME_STORE_TOP_ASSERT_SVH
`define VGA_SCAN_OUT_WITH_FRAME_STORE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VGAFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VGAFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vgafs_pkg.sv
`default_nettype none

package vgafs_pkg;

    // Raster geometry.
    localparam int ACTIVE_WIDTH  = 640;
    localparam int ACTIVE_HEIGHT = 480;
    localparam int H_FRONT       = 16;
    localparam int H_SYNC        = 96;
    localparam int H_BACK        = 48;
    localparam int V_FRONT       = 10;
    localparam int V_SYNC        = 2;
    localparam int V_BACK        = 33;
    localparam int H_TOTAL       = ACTIVE_WIDTH + H_FRONT + H_SYNC + H_BACK;
    localparam int V_TOTAL       = ACTIVE_HEIGHT + V_FRONT + V_SYNC + V_BACK;
    localparam int H_SYNC_START  = ACTIVE_WIDTH + H_FRONT;
    localparam int H_SYNC_END    = ACTIVE_WIDTH + H_FRONT + H_SYNC;
    localparam int V_SYNC_START  = ACTIVE_HEIGHT + V_FRONT;
    localparam int V_SYNC_END    = ACTIVE_HEIGHT + V_FRONT + V_SYNC;

    // Frame store geometry; one store pixel covers 4 columns by 2 lines.
    localparam int STORE_WIDTH   = 160;
    localparam int STORE_HEIGHT  = 240;
    localparam int STORE_SIZE    = STORE_WIDTH * STORE_HEIGHT;
    localparam int X_SHIFT       = 2;
    localparam int Y_SHIFT       = 1;

    localparam int COUNT_W  = $clog2((H_TOTAL > V_TOTAL) ? H_TOTAL : V_TOTAL);
    localparam int ADDR_W   = $clog2(STORE_SIZE);
    localparam int COLOUR_W = 3;
    localparam int FIELD_W  = 8;

    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [FIELD_W-1:0]  field_t;

    // Item kinds carried on tuser.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Information that travels with an item through the RAM read cycle.
    typedef struct packed {
        logic    kind;
        logic    show_pixel;
        logic    hsync;
        logic    vsync;
    } stage_t;

endpackage

`default_nettype wire

// File: design/vgafs_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module vgafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/vga_scan_out_with_frame_store_top.sv
// Pipeline: an accepted input transfer passes the read stage register and then the
// output register before its result reaches the m_ side. Throughput: one transfer
// per cycle while m_tready is high; the frame store RAM has a separate write and
// read port, so a pixel write and a raster tick never compete for a port. Reset:
// aresetn (synchronous, active low) clears counters and colour, sets sync levels high,
// then a clearing pass zeroes all 38400 store entries, one per cycle, with s_tready low.
`default_nettype none

module vga_scan_out_with_frame_store_top (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata: pixel_value [7:0], write_x [15:8], write_y [23:16]
    input  wire  [23:0] s_tdata,
    // s_tuser: kind (0 = tick, 1 = pixel write)
    input  wire         s_tuser,

    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata: hsync_level [0], vsync_level [1], red_level [2], green_level [3],
    // blue_level [4], zero [7:5]
    output logic [7:0]  m_tdata
);

    // ------------------------------------------------------------------
    // Input fields.
    // ------------------------------------------------------------------
    vgafs_pkg::field_t pixel_value;
    vgafs_pkg::field_t write_x;
    vgafs_pkg::field_t write_y;
    logic              kind;

    assign pixel_value = s_tdata[7:0];
    assign write_x     = s_tdata[15:8];
    assign write_y     = s_tdata[23:16];
    assign kind        = s_tuser;

    // ------------------------------------------------------------------
    // State. The counters and sync levels are updated when a tick is
    // accepted. The colour level comes out of the RAM in the cycle after, so it
    // is recorded when the tick leaves the read stage.
    // ------------------------------------------------------------------
    vgafs_pkg::count_t  col_reg, col_next;
    vgafs_pkg::count_t  line_reg, line_next;
    logic               hsync_reg, hsync_next;
    logic               vsync_reg, vsync_next;
    vgafs_pkg::colour_t colour_reg;

    logic               clearing_reg;
    vgafs_pkg::addr_t   clear_cnt_reg;

    logic               s1_valid_reg;
    vgafs_pkg::stage_t  s1_reg, s1_next;

    logic               out_valid_reg;
    logic               out_hsync_reg;
    logic               out_vsync_reg;
    vgafs_pkg::colour_t out_colour_reg;

    logic               accept;
    logic               s1_adv;
    logic               out_adv;

    // The read stage can move on when the output register is empty or being
    // emptied. A new item may enter when the read stage is empty or moving and no clearing pass runs.
    assign out_adv  = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign s_tready = !clearing_reg && (!s1_valid_reg || out_adv);
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Raster position and sync generation.
    // ------------------------------------------------------------------
    logic               is_tick;
    logic               in_active;
    logic               in_store;
    vgafs_pkg::count_t  store_x;
    vgafs_pkg::count_t  store_y;
    vgafs_pkg::addr_t   rd_addr;

    assign is_tick   = (kind == vgafs_pkg::KIND_TICK);
    assign in_active = (col_reg < vgafs_pkg::count_t'(vgafs_pkg::ACTIVE_WIDTH))
                    && (line_reg < vgafs_pkg::count_t'(vgafs_pkg::ACTIVE_HEIGHT));
    assign store_x   = col_reg >> vgafs_pkg::X_SHIFT;
    assign store_y   = line_reg >> vgafs_pkg::Y_SHIFT;
    assign in_store  = (store_x < vgafs_pkg::count_t'(vgafs_pkg::STORE_WIDTH))
                    && (store_y < vgafs_pkg::count_t'(vgafs_pkg::STORE_HEIGHT));

    // Row-major address of the store pixel under the beam; only meaningful
    // when the pixel lies inside the store, which bounds it by the depth.
    assign rd_addr = vgafs_pkg::addr_t'(store_y * vgafs_pkg::STORE_WIDTH + store_x);

    always_comb begin
        col_next   = col_reg;
        line_next  = line_reg;
        hsync_next = hsync_reg;
        vsync_next = vsync_reg;

        if (accept && is_tick) begin
            // Vertical sync changes only at the first column of a line.
            if (col_reg == '0) begin
                if (line_reg == vgafs_pkg::count_t'(vgafs_pkg::V_SYNC_START)) begin
                    vsync_next = 1'b0;
                end
                if (line_reg == vgafs_pkg::count_t'(vgafs_pkg::V_SYNC_END)) begin
                    vsync_next = 1'b1;
                end
            end
            if (col_reg == vgafs_pkg::count_t'(vgafs_pkg::H_SYNC_START)) begin
                hsync_next = 1'b0;
            end
            if (col_reg == vgafs_pkg::count_t'(vgafs_pkg::H_SYNC_END)) begin
                hsync_next = 1'b1;
            end

            // Advance the beam, wrapping at the line and frame totals.
            if (col_reg >= vgafs_pkg::count_t'(vgafs_pkg::H_TOTAL - 1)) begin
                col_next = '0;
                if (line_reg >= vgafs_pkg::count_t'(vgafs_pkg::V_TOTAL - 1)) begin
                    line_next = '0;
                end else begin
                    line_next = line_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // The read stage carries the sync levels as they stand after this item.
    always_comb begin
        s1_next.kind       = kind;
        s1_next.show_pixel = in_active && in_store;
        s1_next.hsync      = hsync_next;
        s1_next.vsync      = vsync_next;
    end

    // ------------------------------------------------------------------
    // Frame store. The write port is shared between the clearing pass and
    // pixel writes; the two never overlap because no transfer is accepted
    // while clearing. A pixel write lands at the edge that accepts it, so a
    // tick accepted in any later cycle reads the new value.
    // ------------------------------------------------------------------
    logic               wr_in_store;
    logic [2*vgafs_pkg::FIELD_W+vgafs_pkg::ADDR_W-1:0] wr_addr_wide;
    logic               ram_wr_en;
    vgafs_pkg::addr_t   ram_wr_addr;
    vgafs_pkg::colour_t ram_wr_data;
    logic               ram_rd_en;
    vgafs_pkg::colour_t ram_rd_data;

    assign wr_in_store  = (write_x < vgafs_pkg::field_t'(vgafs_pkg::STORE_WIDTH))
                       && (write_y < vgafs_pkg::field_t'(vgafs_pkg::STORE_HEIGHT));
    assign wr_addr_wide = write_y * vgafs_pkg::STORE_WIDTH + write_x;

    always_comb begin
        if (clearing_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_cnt_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = accept && !is_tick && wr_in_store;
            ram_wr_addr = wr_addr_wide[vgafs_pkg::ADDR_W-1:0];
            ram_wr_data = pixel_value[vgafs_pkg::COLOUR_W-1:0];
        end
    end

    // Reading only on an accepted tick keeps the read data steady while the
    // read stage is held by a stalled output.
    assign ram_rd_en = accept && is_tick;

    vgafs_ram #(
        .WIDTH (vgafs_pkg::COLOUR_W),
        .DEPTH (vgafs_pkg::STORE_SIZE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Read stage result. A tick takes its colour from the store (blanked
    // outside the active area); a pixel write repeats the last tick's colour.
    // ------------------------------------------------------------------
    vgafs_pkg::colour_t s1_colour;

    always_comb begin
        if (s1_reg.kind == vgafs_pkg::KIND_TICK) begin
            s1_colour = s1_reg.show_pixel ? ram_rd_data : '0;
        end else begin
            s1_colour = colour_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            line_reg      <= '0;
            hsync_reg     <= 1'b1;
            vsync_reg     <= 1'b1;
            colour_reg    <= '0;
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            hsync_reg <= hsync_next;
            vsync_reg <= vsync_next;

            if (clearing_reg) begin
                if (clear_cnt_reg == vgafs_pkg::addr_t'(vgafs_pkg::STORE_SIZE - 1)) begin
                    clearing_reg  <= 1'b0;
                    clear_cnt_reg <= '0;
                end else begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                end
            end

            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                out_valid_reg <= 1'b1;
                colour_reg    <= s1_colour;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (s1_adv) begin
            out_hsync_reg  <= s1_reg.hsync;
            out_vsync_reg  <= s1_reg.vsync;
            out_colour_reg <= s1_colour;
        end
    end

    // ------------------------------------------------------------------
    // Result channel.
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_colour_reg, out_vsync_reg, out_hsync_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "vga_scan_out_with_frame_store_top_assert.svh"

    `VGAFS_ASSERT_NOW(a_no_accept_while_clearing, clearing_reg, !s_tready, "transfer accepted during store clearing")
    `VGAFS_ASSERT_NEXT(a_rd_data_held, s1_valid_reg && !s1_adv, $stable(ram_rd_data), "read data changed under a held read stage")
    `VGAFS_ASSERT_NOW(a_hsync_window, !clearing_reg, hsync_reg == !((col_reg > vgafs_pkg::count_t'(vgafs_pkg::H_SYNC_START)) && (col_reg <= vgafs_pkg::count_t'(vgafs_pkg::H_SYNC_END))), "hsync level does not match column")
    `VGAFS_ASSERT_NOW(a_count_bounds, 1'b1, (col_reg < vgafs_pkg::count_t'(vgafs_pkg::H_TOTAL)) && (line_reg < vgafs_pkg::count_t'(vgafs_pkg::V_TOTAL)), "raster counter out of range")

endmodule

`default_nettype wire
